[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the syllable break inserter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: implication check failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/sbi_pkg.sv]
// Shared types and constants of the syllable break inserter.
package sbi_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEP_MAX  = 8;
    localparam int SEP_W    = SEP_MAX * BYTE_W;
    localparam int LEN_W    = 4;
    localparam int CNT_W    = 4;
    localparam int FLUSH_W  = 2;
    localparam int RUN_W    = 3;

    localparam logic [LEN_W-1:0] SEP_MAX_LEN = LEN_W'(SEP_MAX);
    localparam logic [RUN_W-1:0] RUN_MAX     = '1;
    localparam logic [RUN_W-1:0] RUN_MIN_BRK = RUN_W'(4);

    // Configuration register indexes.
    localparam logic CFG_SEP_BYTES  = 1'b0;
    localparam logic CFG_SEP_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_VOWEL = 2'd0,
        KIND_CONS  = 2'd1,
        KIND_OTHER = 2'd2
    } t_sbi_kind;

    // One command from front to back: an optional delayed byte, then the
    // separator, then the bytes flushed at the end of the text.
    typedef struct packed {
        logic               lead_v;
        logic [BYTE_W-1:0]  lead_byte;
        logic [LEN_W-1:0]   sep_cnt;
        logic [FLUSH_W-1:0] flush_n;
        logic [BYTE_W-1:0]  flush0;
        logic [BYTE_W-1:0]  flush1;
        logic [CNT_W-1:0]   total;
    } t_sbi_cmd;

endpackage

[rtl/core/sbi_front.sv]
// Front end: classifies text bytes, tracks the letter run and the delay line.
module sbi_front
    import sbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_accept,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_in_tail,
    input  logic               i_final_byte,
    input  logic [LEN_W-1:0]   i_sep_length,
    output logic               o_push,
    output t_sbi_cmd           o_cmd
);

    function automatic t_sbi_kind f_kind(input logic [BYTE_W-1:0] b);
        t_sbi_kind k;
        case (b) inside
            8'h00, 8'h84, 8'h96, 8'hA4, 8'hB6, 8'hC3,
            8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h79,
            8'h41, 8'h45, 8'h49, 8'h4F, 8'h55, 8'h59: k = KIND_VOWEL;
            [8'h61:8'h7A], [8'h41:8'h5A]:             k = KIND_CONS;
            default:                                  k = KIND_OTHER;
        endcase
        return k;
    endfunction

    logic [BYTE_W-1:0]  r_d0, r_d1, n_d0, n_d1;
    logic [1:0]         r_fill, n_fill;
    logic [RUN_W-1:0]   r_run, n_run, run_upd;
    logic [1:0]         r_kinds, n_kinds, kinds_upd;
    t_sbi_kind          kind;
    logic               brk;
    logic [LEN_W-1:0]   sep_len;
    logic [1:0]         fill_upd;
    t_sbi_cmd           cmd;

    always_comb begin
        kind = f_kind(i_text_byte);
        if (kind == KIND_OTHER) begin
            run_upd   = '0;
            kinds_upd = '0;
        end else begin
            run_upd   = (r_run == RUN_MAX) ? r_run : r_run + RUN_W'(1);
            kinds_upd = {r_kinds[0], kind == KIND_CONS};
        end
        brk     = !i_in_tail && (run_upd >= RUN_MIN_BRK) && (kinds_upd == 2'b10);
        sep_len = (i_sep_length > SEP_MAX_LEN) ? SEP_MAX_LEN : i_sep_length;

        // With a full delay line the oldest byte leaves either way; at a break
        // it goes out ahead of the separator.
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (r_fill == 2'd2) begin
            n_d0     = r_d1;
            n_d1     = i_text_byte;
            fill_upd = 2'd2;
        end else if (r_fill == 2'd1) begin
            n_d1     = i_text_byte;
            fill_upd = 2'd2;
        end else begin
            n_d0     = i_text_byte;
            fill_upd = 2'd1;
        end

        cmd.lead_v    = (r_fill == 2'd2);
        cmd.lead_byte = r_d0;
        cmd.sep_cnt   = brk ? sep_len : '0;
        cmd.flush_n   = i_final_byte ? fill_upd : '0;
        cmd.flush0    = n_d0;
        cmd.flush1    = n_d1;
        cmd.total     = CNT_W'(cmd.lead_v) + cmd.sep_cnt + CNT_W'(cmd.flush_n);

        if (i_final_byte) begin
            n_fill  = '0;
            n_run   = '0;
            n_kinds = '0;
        end else begin
            n_fill  = fill_upd;
            n_run   = run_upd;
            n_kinds = kinds_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_run   <= '0;
            r_kinds <= '0;
        end else if (i_valid && i_accept) begin
            r_fill  <= n_fill;
            r_run   <= n_run;
            r_kinds <= n_kinds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_accept) begin
            r_d0 <= n_d0;
            r_d1 <= n_d1;
        end
    end

    // Items that produce no output bytes are not queued.
    assign o_push = i_valid && i_accept && (cmd.total != '0);
    assign o_cmd  = cmd;

endmodule

[rtl/core/sbi_queue.sv]
// Two-entry command queue between the front end and the output sequencer.
module sbi_queue
    import sbi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_sbi_cmd i_cmd,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_sbi_cmd o_cmd
);

    `include "assert_macros.svh"

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    t_sbi_cmd            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid)
    `ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n, r_count > Q_CNT_W'(Q_DEPTH))

endmodule

[rtl/core/sbi_back.sv]
// Back end: walks each command byte by byte into the output register.
module sbi_back
    import sbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  t_sbi_cmd           i_head,
    input  logic [SEP_W-1:0]   i_sep_bytes,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [BYTE_W-1:0]  o_m_tdata,
    output logic               o_m_tlast
);

    `include "assert_macros.svh"

    logic [CNT_W-1:0]   r_pos, n_pos;
    logic               r_m_tvalid, n_m_tvalid;
    logic [BYTE_W-1:0]  r_m_tdata;
    logic               r_m_tlast;
    logic               load, emit, last;
    logic [CNT_W-1:0]   q, rem;
    logic [2:0]         sep_idx;
    logic [BYTE_W-1:0]  cur_byte;

    always_comb begin
        q       = r_pos - CNT_W'(i_head.lead_v);
        rem     = q - i_head.sep_cnt;
        sep_idx = q[2:0];
        if (i_head.lead_v && (r_pos == '0)) begin
            cur_byte = i_head.lead_byte;
        end else if (q < i_head.sep_cnt) begin
            cur_byte = i_sep_bytes[{sep_idx, 3'b000} +: BYTE_W];
        end else begin
            cur_byte = rem[0] ? i_head.flush1 : i_head.flush0;
        end
        last = (r_pos == i_head.total - CNT_W'(1));

        load = !r_m_tvalid || i_m_tready;
        emit = i_head_valid && load;

        n_pos = r_pos;
        if (emit) n_pos = last ? '0 : r_pos + CNT_W'(1);

        if (emit)            n_m_tvalid = 1'b1;
        else if (i_m_tready) n_m_tvalid = 1'b0;
        else                 n_m_tvalid = r_m_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_tdata <= cur_byte;
            r_m_tlast <= last && (i_head.flush_n != '0);
        end
    end

    assign o_pop      = emit && last;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    `ASSERT_IMPLY(a_pos_in_range, i_clk, i_rst_n, i_head_valid, r_pos < i_head.total)
    `ASSERT_NEVER(a_pos_idle_zero, i_clk, i_rst_n, !i_head_valid && (r_pos != '0))
    `ASSERT_NEXT(a_tlast_ends_cmd, i_clk, i_rst_n,
        emit && last && (i_head.flush_n != '0), r_pos == '0 && o_m_tlast)

endmodule

[rtl/core/syllable_break_inserter.sv]
// Syllable break inserter: text stream in, hyphenated text stream out.
//
// Input stream (s_*): one text byte per transfer in s_tdata, s_tuser set when
// the byte lies in the last ten bytes of the text, s_tlast on the last byte.
// Output stream (m_*): one byte per transfer, a text byte or a separator
// byte; m_tlast marks the final output byte of a text.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0: separator bytes, first byte lowest; 1: separator length, 0 to 8, larger
// values act as 8). Write only while the block is idle.
// The output bytes of a transfer enter the output register from the next edge
// on when nothing is queued ahead and the receiver keeps up; a text byte
// itself leaves with the transfer two bytes later, or in the end-of-text flush.
// Throughput: one input byte per cycle between breaks while the receiver keeps
// up. A break with separator length L puts up to L+1 output bytes into its
// command, the last byte of a text up to two more, eleven at most.
// The two-entry command queue lets input run ahead; s_tready is low while it
// is full, also in a cycle in which the sequencer frees an entry.
// Reset empties the delay line, the letter run and the queue, and loads the
// separator "-" of length one. When the receiver stalls, the output register
// holds its byte, the queue fills and s_tready drops.
module syllable_break_inserter
    import sbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic               s_tuser,   // [0] in_tail
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic               m_tlast,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [SEP_W-1:0]   i_cfg_data
);

    logic [SEP_W-1:0]  r_sep_bytes;
    logic [LEN_W-1:0]  r_sep_length;
    logic              push, pop, q_full, q_valid;
    t_sbi_cmd          push_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_bytes  <= SEP_W'(8'h2D);
            r_sep_length <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEP_BYTES:  r_sep_bytes  <= i_cfg_data;
                CFG_SEP_LENGTH: r_sep_length <= i_cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign s_tready = !q_full;

    sbi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .i_accept     (s_tready),
        .i_text_byte  (s_tdata),
        .i_in_tail    (s_tuser),
        .i_final_byte (s_tlast),
        .i_sep_length (r_sep_length),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    sbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    sbi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_cmd),
        .i_sep_bytes  (r_sep_bytes),
        .o_pop        (pop),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (m_tdata),
        .o_m_tlast    (m_tlast)
    );

endmodule
